@@ hw/rtl/etagr_pkg.sv @@
// Shared types and constants for the early-terminating agreement block.
// Holds the item structs, command and status codes, and peer flag masks.
// Has no dependencies; early_terminating_agreement imports it.
`default_nettype none

package etagr_pkg;

    // Size of the peer table.
    localparam int MAX_PEERS = 64;
    localparam int MIN_PEERS = 2;

    // Peer table address width and counter widths.
    localparam int PEER_AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int NP_W    = $clog2(MAX_PEERS + 2);
    localparam int CMP_W   = (NP_W > 7) ? NP_W : 7;
    localparam int SUM_W   = CMP_W + 1;

    // One peer table entry.
    localparam int FLAG_W = 5;
    localparam logic [FLAG_W-1:0] F_CRASHED = 5'b00001;
    localparam logic [FLAG_W-1:0] F_RECVD   = 5'b00010;
    localparam logic [FLAG_W-1:0] F_TOLD    = 5'b00100;
    localparam logic [FLAG_W-1:0] F_KIK     = 5'b01000;
    localparam logic [FLAG_W-1:0] F_SENT    = 5'b10000;

    // Commands.
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_MARK_FAIL = 3'd1;
    localparam logic [2:0] CMD_RECV_OK   = 3'd2;
    localparam logic [2:0] CMD_RECV_FAIL = 3'd3;
    localparam logic [2:0] CMD_SEND_OK   = 3'd4;
    localparam logic [2:0] CMD_SEND_FAIL = 3'd5;
    localparam logic [2:0] CMD_END_ROUND = 3'd6;
    localparam logic [2:0] CMD_QUERY     = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK   = 1'd1;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  peer;
        logic [31:0] estimate;
        logic        peer_knows;
        logic        peer_failure_flag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] current_estimate;
        logic        knows_now;
        logic        failure_seen;
        logic        decided;
        logic [6:0]  round_number;
        logic        peer_needs_recv;
        logic        peer_needs_send;
        logic        peer_crashed;
        logic [6:0]  crashed_count;
    } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/etagr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// No dependencies.
`default_nettype none

module etagr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/early_terminating_agreement.sv @@
// Early-terminating agreement, one node's side. Depends on etagr_pkg and etagr_ram.
// A result is registered in S_OUT once the output is free; an end of round while running
// first sweeps the whole peer table through one read port in SWEEP and DRAIN, then FINR.
// A new command is taken only after the last one has left S_OUT; output stalls hold it there.
// Reset (rst_n, asynchronous, active low) clears all control state and the
// per-entry valid bits, so the peer table reads as all zero without a clearing pass.
`default_nettype none

module early_terminating_agreement
    import etagr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Command channel.
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    // Result channel.
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data
);

    // Sequencer states. Ordinary commands go IDLE -> EXEC -> OUT. A running end
    // of round walks the table in SWEEP (reads issued) and DRAIN (last write-back), then
    // applies the termination test in FINR, which also re-reads the queried
    // entry so that EXEC and OUT report it the same way as for any command.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FINR  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            state_reg, state_next;
    in_item_t              item_reg, item_next;
    logic [CFG_DATA_W-1:0] peer_count_reg, peer_count_next;
    logic [5:0]            own_rank_reg, own_rank_next;

    // Scalar agreement state.
    logic [31:0]      estimate_reg, estimate_next;
    logic             own_knows_reg, own_knows_next;
    logic             failure_reg, failure_next;
    logic [CMP_W-1:0] round_reg, round_next;
    logic [CMP_W-1:0] receives_reg, receives_next;
    logic             decided_reg, decided_next;
    logic             active_reg, active_next;
    logic [CMP_W-1:0] crashed_total_reg, crashed_total_next;

    // Peer table bookkeeping. An entry whose valid bit is clear reads as zero.
    logic [MAX_PEERS-1:0] valid_reg, valid_next;
    logic [FLAG_W-1:0]    flags_reg, flags_next;
    logic [1:0]           status_reg, status_next;
    logic                 swept_reg, swept_next;

    // End-of-round sweep pipeline.
    logic [PEER_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [PEER_AW-1:0] wb_idx_reg, wb_idx_next;
    logic               wb_vld_reg, wb_vld_next;
    logic [CMP_W-1:0]   nbc_reg, nbc_next;
    logic [CMP_W-1:0]   nbk_reg, nbk_next;

    // Result register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // RAM ports.
    logic               ram_wr_en;
    logic [PEER_AW-1:0] ram_wr_addr;
    logic [FLAG_W-1:0]  ram_wr_data;
    logic [PEER_AW-1:0] ram_rd_addr;
    logic [FLAG_W-1:0]  ram_rd_data;

    etagr_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_PEERS)
    ) u_peer_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Effective participant count, clamped to between MIN_PEERS and the table size.
    logic [CMP_W-1:0] np;
    logic [SUM_W-1:0] np_plus1;

    always_comb
    begin
        if (CMP_W'(peer_count_reg) < CMP_W'(MIN_PEERS))
        begin
            np = CMP_W'(MIN_PEERS);
        end
        else if (CMP_W'(peer_count_reg) > CMP_W'(MAX_PEERS))
        begin
            np = CMP_W'(MAX_PEERS);
        end
        else
        begin
            np = CMP_W'(peer_count_reg);
        end
    end

    assign np_plus1 = SUM_W'(np) + SUM_W'(1);

    // Per-item decode for EXEC; OUT also uses the peer and running terms.
    logic [PEER_AW-1:0] item_addr;
    logic               item_is_peer;
    logic               running;
    logic [FLAG_W-1:0]  flags_cur;
    logic               need_recv_cur;
    logic               need_send_cur;

    assign item_addr    = PEER_AW'(item_reg.peer);
    assign item_is_peer = (CMP_W'(item_reg.peer) < np) && (item_reg.peer != own_rank_reg);
    assign running      = active_reg && !decided_reg;
    assign flags_cur    = valid_reg[item_addr] ? ram_rd_data : '0;
    assign need_recv_cur = running && item_is_peer &&
                           ((flags_cur & (F_CRASHED | F_TOLD | F_RECVD)) == '0);
    assign need_send_cur = running && item_is_peer &&
                           ((flags_cur & (F_CRASHED | F_KIK | F_SENT)) == '0);

    // Sweep write-back decode.
    logic [FLAG_W-1:0] wb_flags;
    logic              wb_in_range;

    assign wb_flags    = valid_reg[wb_idx_reg] ? ram_rd_data : '0;
    assign wb_in_range = CMP_W'(wb_idx_reg) < np;

    // Termination test terms.
    logic [SUM_W-1:0] known_sum;
    logic [SUM_W-1:0] progress_sum;

    assign known_sum    = SUM_W'(nbk_reg) + SUM_W'(nbc_reg) + SUM_W'(1);
    assign progress_sum = SUM_W'(receives_reg) + SUM_W'(round_reg);

    logic in_xfer;
    logic out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next         = state_reg;
        item_next          = item_reg;
        peer_count_next    = peer_count_reg;
        own_rank_next      = own_rank_reg;
        estimate_next      = estimate_reg;
        own_knows_next     = own_knows_reg;
        failure_next       = failure_reg;
        round_next         = round_reg;
        receives_next      = receives_reg;
        decided_next       = decided_reg;
        active_next        = active_reg;
        crashed_total_next = crashed_total_reg;
        valid_next         = valid_reg;
        flags_next         = flags_reg;
        status_next        = status_reg;
        swept_next         = swept_reg;
        rd_idx_next        = rd_idx_reg;
        wb_idx_next        = wb_idx_reg;
        wb_vld_next        = 1'b0;
        nbc_next           = nbc_reg;
        nbk_next           = nbk_reg;
        out_data_next      = out_data_reg;
        out_valid_next     = out_valid_reg && out_stall;

        ram_wr_en   = 1'b0;
        ram_wr_addr = item_addr;
        ram_wr_data = flags_cur;
        ram_rd_addr = PEER_AW'(in_data.peer);

        // Configuration must only be written while idle; this is not enforced.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PEER_COUNT: peer_count_next = cfg_data;
                CFG_OWN_RANK:   own_rank_next   = cfg_data[5:0];
                default:        ;
            endcase
        end

        // A write-back is pending for the entry read in the previous cycle.
        // Counting takes crashed first, otherwise told-me-it-knows.
        if (wb_vld_reg)
        begin
            if (wb_in_range)
            begin
                if ((wb_flags & F_CRASHED) != '0)
                begin
                    nbc_next = nbc_reg + CMP_W'(1);
                end
                else if ((wb_flags & F_TOLD) != '0)
                begin
                    nbk_next = nbk_reg + CMP_W'(1);
                end
            end
            ram_wr_en   = valid_reg[wb_idx_reg];
            ram_wr_addr = wb_idx_reg;
            ram_wr_data = wb_flags & ~(F_RECVD | F_SENT);
        end

        case (state_reg)
            S_IDLE:
            begin
                // The read of the addressed entry is issued with the transfer.
                if (in_xfer)
                begin
                    item_next  = in_data;
                    swept_next = 1'b0;
                    nbc_next   = '0;
                    nbk_next   = '0;
                    if ((in_data.command == CMD_END_ROUND) && running)
                    begin
                        rd_idx_next = '0;
                        state_next  = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_SWEEP:
            begin
                ram_rd_addr = rd_idx_reg;
                wb_idx_next = rd_idx_reg;
                wb_vld_next = 1'b1;
                rd_idx_next = rd_idx_reg + PEER_AW'(1);
                if (rd_idx_reg == PEER_AW'(MAX_PEERS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_FINR;
            end

            S_FINR:
            begin
                ram_rd_addr        = item_addr;
                crashed_total_next = nbc_reg;
                receives_next      = '0;
                swept_next         = 1'b1;
                if ((known_sum >= SUM_W'(np)) && own_knows_reg)
                begin
                    decided_next = 1'b1;
                end
                else
                begin
                    own_knows_next = (nbk_reg != '0) || (progress_sum >= np_plus1);
                    if (SUM_W'(round_reg) >= np_plus1)
                    begin
                        decided_next = 1'b1;
                    end
                    else
                    begin
                        round_next = round_reg + CMP_W'(1);
                    end
                end
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                flags_next  = flags_cur;
                status_next = ST_OK;
                state_next  = S_OUT;
                if (item_reg.command == CMD_START)
                begin
                    valid_next         = '0;
                    flags_next         = '0;
                    estimate_next      = item_reg.estimate;
                    own_knows_next     = 1'b0;
                    failure_next       = 1'b0;
                    round_next         = CMP_W'(1);
                    receives_next      = '0;
                    decided_next       = 1'b0;
                    active_next        = 1'b1;
                    crashed_total_next = '0;
                end
                else if (item_reg.command == CMD_QUERY)
                begin
                    status_next = ST_OK;
                end
                else if (item_reg.command == CMD_END_ROUND)
                begin
                    status_next = swept_reg ? ST_OK : ST_INACTIVE;
                end
                else if (!running)
                begin
                    status_next = ST_INACTIVE;
                end
                else
                begin
                    case (item_reg.command)
                        CMD_MARK_FAIL:
                        begin
                            if (item_is_peer)
                            begin
                                flags_next = flags_cur | F_CRASHED;
                            end
                            else
                            begin
                                status_next = ST_IGNORED;
                            end
                        end
                        CMD_RECV_OK:
                        begin
                            if (need_recv_cur)
                            begin
                                estimate_next = estimate_reg & item_reg.estimate;
                                failure_next  = failure_reg | item_reg.peer_failure_flag;
                                flags_next    = flags_cur | F_RECVD |
                                                (item_reg.peer_knows ? F_TOLD : '0);
                                receives_next = receives_reg + CMP_W'(1);
                            end
                            else
                            begin
                                status_next = ST_IGNORED;
                            end
                        end
                        CMD_RECV_FAIL:
                        begin
                            if (need_recv_cur)
                            begin
                                flags_next   = flags_cur | F_CRASHED | F_RECVD;
                                failure_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_IGNORED;
                            end
                        end
                        CMD_SEND_OK:
                        begin
                            if (need_send_cur)
                            begin
                                flags_next = flags_cur | F_SENT |
                                             (own_knows_reg ? F_KIK : '0);
                            end
                            else
                            begin
                                status_next = ST_IGNORED;
                            end
                        end
                        CMD_SEND_FAIL:
                        begin
                            if (need_send_cur)
                            begin
                                flags_next   = flags_cur | F_CRASHED | F_SENT;
                                failure_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_IGNORED;
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                        end
                    endcase
                    // Write the modified entry back; only real peers are ever touched.
                    if (status_next == ST_OK)
                    begin
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = item_addr;
                        ram_wr_data            = flags_next;
                        valid_next[item_addr]  = 1'b1;
                    end
                end
            end

            S_OUT:
            begin
                // The result reflects the state after the command; the per-peer
                // fields are zero for self and out-of-range peers.
                if (out_free)
                begin
                    out_data_next.status           = status_reg;
                    out_data_next.current_estimate = estimate_reg;
                    out_data_next.knows_now        = own_knows_reg;
                    out_data_next.failure_seen     = failure_reg;
                    out_data_next.decided          = decided_reg;
                    out_data_next.round_number     = 7'(round_reg);
                    out_data_next.peer_needs_recv  = running && item_is_peer &&
                        ((flags_reg & (F_CRASHED | F_TOLD | F_RECVD)) == '0);
                    out_data_next.peer_needs_send  = running && item_is_peer &&
                        ((flags_reg & (F_CRASHED | F_KIK | F_SENT)) == '0);
                    out_data_next.peer_crashed     = item_is_peer &&
                        ((flags_reg & F_CRASHED) != '0);
                    out_data_next.crashed_count    = 7'(crashed_total_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            peer_count_reg    <= CFG_DATA_W'(MIN_PEERS);
            own_rank_reg      <= '0;
            estimate_reg      <= '0;
            own_knows_reg     <= 1'b0;
            failure_reg       <= 1'b0;
            round_reg         <= '0;
            receives_reg      <= '0;
            decided_reg       <= 1'b0;
            active_reg        <= 1'b0;
            crashed_total_reg <= '0;
            valid_reg         <= '0;
            swept_reg         <= 1'b0;
            wb_vld_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            peer_count_reg    <= peer_count_next;
            own_rank_reg      <= own_rank_next;
            estimate_reg      <= estimate_next;
            own_knows_reg     <= own_knows_next;
            failure_reg       <= failure_next;
            round_reg         <= round_next;
            receives_reg      <= receives_next;
            decided_reg       <= decided_next;
            active_reg        <= active_next;
            crashed_total_reg <= crashed_total_next;
            valid_reg         <= valid_next;
            swept_reg         <= swept_next;
            wb_vld_reg        <= wb_vld_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload and datapath registers without reset.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        flags_reg    <= flags_next;
        status_reg   <= status_next;
        rd_idx_reg   <= rd_idx_next;
        wb_idx_reg   <= wb_idx_next;
        nbc_reg      <= nbc_next;
        nbk_reg      <= nbk_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
